FILE: design/owring_pkg.sv
package owring_pkg;

    // Field widths fixed by the item format.
    localparam int HANDLE_W = 32;
    localparam int LENGTH_W = 20;
    localparam int OFFSET_W = 24;
    localparam int SLOT_W   = 4;

    // Operation codes carried in the op field.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add;       // store the incoming entry
        logic start;     // capture the offset and rewind the walk
        logic walk;      // issue the next read and evaluate the last one
        logic latch;     // capture the walk outcome
        logic load_out;  // move the captured outcome into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;      // the entry under evaluation ends the walk
    } t_status;

endpackage

FILE: design/owring_ctrl.sv
module owring_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_op,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  owring_pkg::t_status  i_status,
    output owring_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Inputs are taken only between walks.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == owring_pkg::OP_FIND) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_WALK;
                    end else begin
                        o_cmd.add = 1'b1;
                    end
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.done) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The output beat stays until it is taken.
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: design/owring_datapath.sv
module owring_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  owring_pkg::t_cmd                    i_cmd,
    output owring_pkg::t_status                 o_status,
    input  logic [owring_pkg::HANDLE_W-1:0]     i_new_handle,
    input  logic [owring_pkg::LENGTH_W-1:0]     i_new_length,
    input  logic [owring_pkg::OFFSET_W-1:0]     i_seek_offset,
    output logic                                o_found,
    output logic [owring_pkg::SLOT_W-1:0]       o_slot,
    output logic [owring_pkg::HANDLE_W-1:0]     o_hit_handle,
    output logic [owring_pkg::LENGTH_W-1:0]     o_hit_length,
    output logic [owring_pkg::LENGTH_W-1:0]     o_inner_offset
);

    localparam int HW    = owring_pkg::HANDLE_W;
    localparam int LW    = owring_pkg::LENGTH_W;
    localparam int OW    = owring_pkg::OFFSET_W;
    localparam int SW    = owring_pkg::SLOT_W;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SUM_W = LW + IDX_W;
    localparam int CMP_W = (SUM_W > OW) ? SUM_W : OW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] NUM_CNT  = CNT_W'(ENTRIES);

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] s);
        return (s == LAST_IDX) ? '0 : s + 1'b1;
    endfunction

    // Entry store; the valid bits make never-written entries read as empty.
    logic [HW-1:0]      mem_handle [ENTRIES];
    logic [LW-1:0]      mem_length [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    logic [IDX_W-1:0] r_wr_slot;
    logic [IDX_W-1:0] r_rd_slot;
    logic             r_full;

    // Walk state.
    logic [OW-1:0]    r_seek;
    logic [IDX_W-1:0] r_ridx;
    logic [CNT_W-1:0] r_icnt;
    logic             r_pend;
    logic             r_last;
    logic [IDX_W-1:0] r_eidx;
    logic [HW-1:0]    r_rd_handle;
    logic [LW-1:0]    r_rd_length;
    logic             r_rd_vld;
    logic [SUM_W-1:0] r_sum;

    // Captured outcome and output register.
    logic             r_res_found;
    logic [SW-1:0]    r_res_slot;
    logic [HW-1:0]    r_res_handle;
    logic [LW-1:0]    r_res_length;
    logic [LW-1:0]    r_res_inner;
    logic             r_out_found;
    logic [SW-1:0]    r_out_slot;
    logic [HW-1:0]    r_out_handle;
    logic [LW-1:0]    r_out_length;
    logic [LW-1:0]    r_out_inner;

    logic [IDX_W-1:0]   rd_next;
    logic [IDX_W-1:0]   wr_next;
    logic               live;
    logic [SUM_W-1:0]   sum_next;
    logic [CMP_W-1:0]   sum_cmp;
    logic [CMP_W-1:0]   seek_cmp;
    logic [CMP_W-1:0]   inner_full;
    logic               hit;
    logic [IDX_W+SW-1:0] slot_ext;

    assign rd_next = next_idx(r_rd_slot);
    assign wr_next = next_idx(r_wr_slot);

    // Evaluation of the entry whose read came back this cycle.
    assign live       = r_pend && r_rd_vld && (r_rd_handle != '0);
    assign sum_next   = r_sum + SUM_W'(r_rd_length);
    assign sum_cmp    = CMP_W'(sum_next);
    assign seek_cmp   = CMP_W'(r_seek);
    assign hit        = live && (sum_cmp > seek_cmp);
    assign inner_full = seek_cmp - CMP_W'(r_sum);
    assign slot_ext   = (IDX_W + SW)'(r_eidx);

    assign o_status.done = r_pend && (hit || r_last);

    // Ring pointers and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_rd_slot <= '0;
            r_full    <= 1'b0;
            r_valid   <= '0;
        end else if (i_cmd.add) begin
            r_valid[r_wr_slot] <= 1'b1;
            r_wr_slot          <= wr_next;
            if (r_full) begin
                r_rd_slot <= rd_next;
            end else if (wr_next == r_rd_slot) begin
                r_full <= 1'b1;
            end
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            mem_handle[r_wr_slot] <= i_new_handle;
            mem_length[r_wr_slot] <= i_new_length;
        end
        r_rd_handle <= mem_handle[r_ridx];
        r_rd_length <= mem_length[r_ridx];
        r_rd_vld    <= r_valid[r_ridx];
    end

    // Walk control: one read issued per cycle from the oldest slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_icnt <= '0;
        end else if (i_cmd.start) begin
            r_pend <= 1'b0;
            r_icnt <= '0;
        end else if (i_cmd.walk) begin
            if (r_icnt < NUM_CNT) begin
                r_pend <= 1'b1;
                r_icnt <= r_icnt + 1'b1;
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    // Walk payload: read index, data tags and running length.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_seek <= i_seek_offset;
            r_ridx <= r_rd_slot;
            r_sum  <= '0;
        end else if (i_cmd.walk) begin
            r_ridx <= next_idx(r_ridx);
            r_eidx <= r_ridx;
            r_last <= (r_icnt == LAST_CNT);
            if (live) begin
                r_sum <= sum_next;
            end
        end
    end

    // Capture the outcome, zeros when nothing matched, and move it into the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_res_found <= hit;
            if (hit) begin
                r_res_slot   <= slot_ext[SW-1:0];
                r_res_handle <= r_rd_handle;
                r_res_length <= r_rd_length;
                r_res_inner  <= inner_full[LW-1:0];
            end else begin
                r_res_slot   <= '0;
                r_res_handle <= '0;
                r_res_length <= '0;
                r_res_inner  <= '0;
            end
        end
        if (i_cmd.load_out) begin
            r_out_found  <= r_res_found;
            r_out_slot   <= r_res_slot;
            r_out_handle <= r_res_handle;
            r_out_length <= r_res_length;
            r_out_inner  <= r_res_inner;
        end
    end

    assign o_found        = r_out_found;
    assign o_slot         = r_out_slot;
    assign o_hit_handle   = r_out_handle;
    assign o_hit_length   = r_out_length;
    assign o_inner_offset = r_out_inner;

endmodule

FILE: design/overwriting_ring_with_offset_lookup_unit.sv
// Ring of ENTRIES entries (handle, byte length) that overwrites its oldest
// entry once full. An add beat (op = 0) is stored and gives no result. A
// find beat (op = 1) walks the stored entries from the oldest, one memory
// read per cycle, skipping entries with a zero handle, and gives one result
// beat: the first entry whose running length passes seek_offset and the
// offset inside it, or found = 0 with all other fields zero. The walk is
// paced by the single read port of the entry memory and ends early on a
// hit; the input stalls during the walk. Entries never written since reset
// read as empty through per-entry valid bits, so there is no clearing pass.
// The full flag clears only at reset.
module overwriting_ring_with_offset_lookup_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic [owring_pkg::HANDLE_W-1:0]  i_new_handle,
    input  logic [owring_pkg::LENGTH_W-1:0]  i_new_length,
    input  logic [owring_pkg::OFFSET_W-1:0]  i_seek_offset,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found,
    output logic [owring_pkg::SLOT_W-1:0]    o_slot,
    output logic [owring_pkg::HANDLE_W-1:0]  o_hit_handle,
    output logic [owring_pkg::LENGTH_W-1:0]  o_hit_length,
    output logic [owring_pkg::LENGTH_W-1:0]  o_inner_offset
);

    owring_pkg::t_cmd    cmd;
    owring_pkg::t_status status;

    // Sequencer for add, walk and result hand-off.
    owring_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Entry store, pointers and offset search.
    owring_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_new_handle   (i_new_handle),
        .i_new_length   (i_new_length),
        .i_seek_offset  (i_seek_offset),
        .o_found        (o_found),
        .o_slot         (o_slot),
        .o_hit_handle   (o_hit_handle),
        .o_hit_length   (o_hit_length),
        .o_inner_offset (o_inner_offset)
    );

endmodule
